FILE: hw/rtl/vemp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vemp_pkg: shared types and constants for the varint entity message parser
// Transaction payload structs, status codes, tag classes and queue sizing.
// ----------------------------------------------------------------------------
package vemp_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_OVERLONG  = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_WIRE_TYPE = 3'd4,
		ST_NO_ENTITY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		TAG_OTHER     = 2'd0,
		TAG_ENTITY    = 2'd1,
		TAG_COMPONENT = 2'd2
	} tag_class_t;

	localparam logic KIND_COMPONENT = 1'b0;
	localparam logic KIND_END       = 1'b1;

	localparam logic [63:0] TAG_ENTITY_VAL    = 64'h08;
	localparam logic [63:0] TAG_COMPONENT_VAL = 64'h10;
	localparam logic [3:0]  MAX_SHIFT_COUNT   = 4'd9;
	localparam int unsigned VARINT_STEP       = 7;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic               record_kind;
		logic [31:0]        component_id;
		logic signed [63:0] entity_id;
		logic [31:0]        id_count;
		status_t            status;
		logic               last_record;
	} record_t;

	typedef struct packed {
		logic    comp_valid;
		logic    end_valid;
		record_t comp_rec;
		record_t end_rec;
	} push_t;

endpackage

FILE: hw/rtl/vemp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vemp_queue: result record queue
// Takes up to two records per cycle, presents one record per transaction.
// ----------------------------------------------------------------------------
module vemp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  vemp_pkg::push_t push,
	output logic            room,
	output logic            rec_valid,
	input  logic            rec_stall,
	output vemp_pkg::record_t rec_item
);
	import vemp_pkg::*;

	record_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  pop;
	logic [QUEUE_AW-1:0]   end_ptr;
	logic [QUEUE_CW-1:0]   push_n;

	assign rec_valid = (count_q != '0);
	assign rec_item  = mem_q[rd_ptr_q];
	assign pop       = rec_valid && !rec_stall;
	assign room      = (count_q <= QUEUE_CW'(QUEUE_DEPTH - 2));
	assign end_ptr   = push.comp_valid ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
	assign push_n    = QUEUE_CW'(push.comp_valid) + QUEUE_CW'(push.end_valid);

	always_ff @(posedge clk) begin
		if (push.comp_valid) begin
			mem_q[wr_ptr_q] <= push.comp_rec;
		end
		if (push.end_valid) begin
			mem_q[end_ptr] <= push.end_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			count_q <= count_q + push_n - QUEUE_CW'(pop);
		end
	end

endmodule

FILE: hw/rtl/vemp_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vemp_decoder: input register and varint field decoder
// Registers one byte, folds it into the varint state, builds records.
// ----------------------------------------------------------------------------
module vemp_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  vemp_pkg::byte_item_t byte_item,
	input  logic                 room,
	output vemp_pkg::push_t      push
);
	import vemp_pkg::*;

	logic        valid_s1;
	byte_item_t  item_s1;
	logic        take;

	logic [63:0] acc_q,  acc_n;
	logic [3:0]  sc_q,   sc_n;
	logic        phase_q, phase_n;
	tag_class_t  tag_q,  tag_n;
	logic [63:0] ent_q,  ent_n;
	logic        seen_q, seen_n;
	status_t     err_q,  err_n;
	logic [1:0]  bc_q,   bc_n;
	logic [31:0] ids_q,  ids_n;

	logic [5:0]  sh;
	logic [63:0] acc_or;
	logic        emit_comp;
	status_t     st;

	assign take       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	assign sh     = 6'({2'b00, sc_q} * 6'(VARINT_STEP));
	assign acc_or = acc_q | ({57'd0, item_s1.data_byte[6:0]} << sh);

	always_comb begin
		acc_n     = acc_q;
		sc_n      = sc_q;
		phase_n   = phase_q;
		tag_n     = tag_q;
		ent_n     = ent_q;
		seen_n    = seen_q;
		err_n     = err_q;
		ids_n     = ids_q;
		emit_comp = 1'b0;
		bc_n      = (bc_q < 2'd2) ? bc_q + 2'd1 : bc_q;

		if (err_q == ST_OK) begin
			acc_n = acc_or;
			if (!item_s1.data_byte[7]) begin
				if (!phase_q) begin
					if (acc_or[2:0] != 3'd0) begin
						err_n = ST_WIRE_TYPE;
					end else begin
						tag_n   = (acc_or == TAG_ENTITY_VAL)    ? TAG_ENTITY :
						          (acc_or == TAG_COMPONENT_VAL) ? TAG_COMPONENT : TAG_OTHER;
						phase_n = 1'b1;
					end
				end else begin
					if (tag_q == TAG_ENTITY) begin
						ent_n  = acc_or;
						seen_n = 1'b1;
					end else if (tag_q == TAG_COMPONENT) begin
						emit_comp = 1'b1;
						if (ids_q != '1) begin
							ids_n = ids_q + 32'd1;
						end
					end
					phase_n = 1'b0;
					tag_n   = TAG_OTHER;
				end
				acc_n = '0;
				sc_n  = '0;
			end else if (sc_q >= MAX_SHIFT_COUNT) begin
				err_n = ST_OVERLONG;
			end else begin
				sc_n = sc_q + 4'd1;
			end
		end

		if (bc_n < 2'd2) begin
			st = ST_SHORT;
		end else if (err_n != ST_OK) begin
			st = err_n;
		end else if (sc_n != 4'd0 || phase_n) begin
			st = ST_TRUNCATED;
		end else if (!seen_n) begin
			st = ST_NO_ENTITY;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		push.comp_valid            = take && emit_comp;
		push.end_valid             = take && item_s1.last_byte;
		push.comp_rec.record_kind  = KIND_COMPONENT;
		push.comp_rec.component_id = acc_or[31:0];
		push.comp_rec.entity_id    = '0;
		push.comp_rec.id_count     = '0;
		push.comp_rec.status       = ST_OK;
		push.comp_rec.last_record  = 1'b0;
		push.end_rec.record_kind   = KIND_END;
		push.end_rec.component_id  = '0;
		push.end_rec.entity_id     = (st == ST_OK) ? ent_n : '0;
		push.end_rec.id_count      = ids_n;
		push.end_rec.status        = st;
		push.end_rec.last_record   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			sc_q    <= '0;
			phase_q <= 1'b0;
			tag_q   <= TAG_OTHER;
			ent_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= ST_OK;
			bc_q    <= '0;
			ids_q   <= '0;
		end else if (take) begin
			if (item_s1.last_byte) begin
				acc_q   <= '0;
				sc_q    <= '0;
				phase_q <= 1'b0;
				tag_q   <= TAG_OTHER;
				ent_q   <= '0;
				seen_q  <= 1'b0;
				err_q   <= ST_OK;
				bc_q    <= '0;
				ids_q   <= '0;
			end else begin
				acc_q   <= acc_n;
				sc_q    <= sc_n;
				phase_q <= phase_n;
				tag_q   <= tag_n;
				ent_q   <= ent_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
				bc_q    <= bc_n;
				ids_q   <= ids_n;
			end
		end
	end

endmodule

FILE: hw/rtl/varint_entity_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_entity_message_parser: top level
// Decodes a byte stream of varint tag/value fields into component id records
// and one end record per message.
//
// Input channel byte_valid/byte_stall/byte_item moves one message byte per
// transaction, last_byte marking the final byte of the message.
// Output channel rec_valid/rec_stall/rec_item moves one record per
// transaction: a component id record for each tag 16 value, then an end
// record with entity id, id count and status on the final byte.
// A byte is held in the input register and decoded there into the varint
// state; its records are written to the queue memory and read out from it.
// Throughput: one byte per cycle while the queue has room; a final byte that
// also completes a component value yields two records, which drain at one
// per cycle while the receiver does not stall, through a four-entry record
// queue. The input stalls while that queue holds more than two records.
// Reset clears the decoder state and empties the queue. A stalled receiver
// holds the head record steady; once the queue holds more than two records,
// byte_stall rises.
module varint_entity_message_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  vemp_pkg::byte_item_t byte_item,
	output logic                 rec_valid,
	input  logic                 rec_stall,
	output vemp_pkg::record_t    rec_item
);
	import vemp_pkg::*;

	push_t push;
	logic  room;

	vemp_decoder u_decoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.room       (room),
		.push       (push)
	);

	vemp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_item  (rec_item)
	);

endmodule

FILE: hw/rtl/vemp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vemp_checker: port-level checks for the varint entity message parser
// Watches the record channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module vemp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rec_valid,
	input logic              rec_stall,
	input vemp_pkg::record_t rec_item
);
	import vemp_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid)
		else $error("record valid dropped while stalled");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> $stable(rec_item))
		else $error("record changed while stalled");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> ((rec_item.record_kind == KIND_END) == rec_item.last_record))
		else $error("record kind and last mark disagree");

	a_entity_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.status != ST_OK |-> rec_item.entity_id == '0)
		else $error("entity id reported with an error status");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rec_valid)
		else $error("record presented out of reset");

endmodule

bind varint_entity_message_parser vemp_checker u_vemp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec_valid),
	.rec_stall (rec_stall),
	.rec_item  (rec_item)
);
